// ----- hw/rtl/htfd_pkg.sv -----
// htfd_pkg: shared types, constants and the crc-8 step of the frame decoder
// no dependencies; used by every module of the frame decoder by scoped names

package htfd_pkg;

  // frame layout
  localparam int FRAME_BYTES = 6;

  // crc-8, polynomial 0x31, init 0xff, no reflection, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // scale factors: temperature 17500/65535 minus 4500, humidity 10000/65535
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;

  // configuration register indexes
  localparam logic CFG_TEMP_LOW  = 1'b0;
  localparam logic CFG_TEMP_HIGH = 1'b1;

  // configuration reset values
  localparam logic [15:0] TEMP_LOW_RESET  = 16'd9363;
  localparam logic [15:0] TEMP_HIGH_RESET = 16'd63662;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_CRC   = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // frame queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // byte position within a frame
  typedef logic [2:0] byte_pos_t;

  localparam byte_pos_t POS_TEMP_HI = 3'd0;
  localparam byte_pos_t POS_TEMP_LO = 3'd1;
  localparam byte_pos_t POS_TEMP_CRC = 3'd2;
  localparam byte_pos_t POS_HUM_HI  = 3'd3;
  localparam byte_pos_t POS_HUM_LO  = 3'd4;
  localparam byte_pos_t POS_HUM_CRC = 3'd5;

  // one decoded frame, as handed from front to back
  typedef struct packed {
    logic [15:0] temp_code;
    logic [15:0] hum_code;
    logic [1:0]  status;
  } frame_t;

  // queue handshake seen by the consumer
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } queue_out_t;

  // one crc-8 byte update, eight bit steps
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/humidity_temperature_frame_decoder_core.sv -----
// humidity_temperature_frame_decoder_core: top level of the sensor frame decoder
// depends on htfd_pkg, htfd_front, htfd_queue and htfd_back
//
//   channel  direction  handshake             payload
//   in       request in in_valid / in_stall   data_byte, frame_start
//   out      request out out_valid / out_stall temperature_centi, humidity_centi, status
//   cfg      write       cfg_write             cfg_index, cfg_data
//
// one byte request is taken per cycle while in_stall is low; after the sixth byte
// of a frame a result passes the queue, multiply, divide-by-65535 add, output register.
// reset is synchronous and clears the frame position, crc, queue and pipeline.
// the four-entry frame queue lets bytes keep flowing while out_stall holds
// results; in_stall rises only when that queue is full.

module humidity_temperature_frame_decoder_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi,
  output logic [1:0]         status,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  logic                 queue_full;
  logic                 push;
  htfd_pkg::frame_t     push_frame;
  logic                 pop;
  htfd_pkg::queue_out_t head;

  assign in_stall = queue_full;

  // front: byte intake and crc
  htfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .queue_full  (queue_full),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .push_frame  (push_frame)
  );

  // frame queue
  htfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .full       (queue_full),
    .pop        (pop),
    .head       (head)
  );

  // back: scaling and result register
  htfd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .status            (status)
  );

endmodule

// ----- hw/rtl/htfd_front.sv -----
// htfd_front: byte intake, crc checking, frame assembly and range check
// depends on htfd_pkg; pushes one frame_t per complete frame into the queue

module htfd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       data_byte,
  input  logic             frame_start,
  input  logic             queue_full,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data,
  output logic             push,
  output htfd_pkg::frame_t push_frame
);

  logic [15:0]         temp_low;
  logic [15:0]         temp_high;
  htfd_pkg::byte_pos_t pos;
  htfd_pkg::byte_pos_t pos_next;
  logic [7:0]          crc;
  logic [7:0]          crc_next;
  logic                failed;
  logic                failed_next;
  logic [15:0]         temp_code;
  logic [15:0]         temp_code_next;
  logic [7:0]          hum_hi;
  logic [7:0]          hum_hi_next;

  logic                accept;
  logic                restart;
  htfd_pkg::byte_pos_t pos_eff;
  logic [7:0]          crc_eff;
  logic                failed_eff;
  logic [7:0]          crc_upd;
  logic                crc_bad;
  logic                fail_final;
  logic                range_bad;

  assign accept = in_valid && !queue_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_low  <= htfd_pkg::TEMP_LOW_RESET;
      temp_high <= htfd_pkg::TEMP_HIGH_RESET;
    end else if (cfg_write) begin
      if (cfg_index == htfd_pkg::CFG_TEMP_LOW) begin
        temp_low <= cfg_data;
      end else begin
        temp_high <= cfg_data;
      end
    end
  end

  // frame restart on start flag or past the last byte
  assign restart    = frame_start || (pos > htfd_pkg::POS_HUM_CRC);
  assign pos_eff    = restart ? htfd_pkg::POS_TEMP_HI : pos;
  assign crc_eff    = restart ? htfd_pkg::CRC_INIT : crc;
  assign failed_eff = restart ? 1'b0 : failed;
  assign crc_upd    = htfd_pkg::crc8_byte(crc_eff, data_byte);
  assign crc_bad    = (crc_eff != data_byte);

  // byte position decode
  always_comb begin
    pos_next       = pos;
    crc_next       = crc;
    failed_next    = failed;
    temp_code_next = temp_code;
    hum_hi_next    = hum_hi;
    push           = 1'b0;
    fail_final     = failed_eff;
    if (accept) begin
      pos_next    = pos_eff + 3'd1;
      crc_next    = crc_upd;
      failed_next = failed_eff;
      case (pos_eff)
        htfd_pkg::POS_TEMP_HI: begin
          temp_code_next = {data_byte, 8'h00};
        end
        htfd_pkg::POS_TEMP_LO: begin
          temp_code_next = {temp_code[15:8], data_byte};
        end
        htfd_pkg::POS_TEMP_CRC: begin
          failed_next = failed_eff || crc_bad;
          crc_next    = htfd_pkg::CRC_INIT;
        end
        htfd_pkg::POS_HUM_HI: begin
          hum_hi_next = data_byte;
        end
        htfd_pkg::POS_HUM_LO: begin
        end
        default: begin
          // last byte closes the frame
          fail_final  = failed_eff || crc_bad;
          push        = 1'b1;
          pos_next    = htfd_pkg::POS_TEMP_HI;
          crc_next    = htfd_pkg::CRC_INIT;
          failed_next = 1'b0;
        end
      endcase
    end
  end

  // humidity low byte is taken on the fly at the last-but-one position
  logic [7:0] hum_lo;
  always_ff @(posedge clk) begin
    if (accept && (pos_eff == htfd_pkg::POS_HUM_LO)) begin
      hum_lo <= data_byte;
    end
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= htfd_pkg::POS_TEMP_HI;
      crc       <= htfd_pkg::CRC_INIT;
      failed    <= 1'b0;
      temp_code <= '0;
      hum_hi    <= '0;
    end else begin
      pos       <= pos_next;
      crc       <= crc_next;
      failed    <= failed_next;
      temp_code <= temp_code_next;
      hum_hi    <= hum_hi_next;
    end
  end

  // status with crc failure ahead of range
  assign range_bad = (temp_code < temp_low) || (temp_code > temp_high);

  always_comb begin
    push_frame.temp_code = temp_code;
    push_frame.hum_code  = {hum_hi, hum_lo};
    if (fail_final) begin
      push_frame.status = htfd_pkg::STATUS_CRC;
    end else if (range_bad) begin
      push_frame.status = htfd_pkg::STATUS_RANGE;
    end else begin
      push_frame.status = htfd_pkg::STATUS_OK;
    end
  end

endmodule

// ----- hw/rtl/htfd_queue.sv -----
// htfd_queue: short frame queue between the front and the back
// depends on htfd_pkg for frame_t and the queue depth

module htfd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  htfd_pkg::frame_t     push_frame,
  output logic                 full,
  input  logic                 pop,
  output htfd_pkg::queue_out_t head
);

  htfd_pkg::frame_t                mem [htfd_pkg::QUEUE_DEPTH];
  logic [htfd_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [htfd_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [htfd_pkg::QUEUE_AW:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (count == (htfd_pkg::QUEUE_AW + 1)'(htfd_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && (count != '0);

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_frame;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.frame = mem[rd_ptr];

endmodule

// ----- hw/rtl/htfd_back.sv -----
// htfd_back: scaling pipeline from raw codes to centi units, output register
// depends on htfd_pkg; pulls frames from htfd_queue, drives the result channel

module htfd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  htfd_pkg::queue_out_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [14:0]   temperature_centi,
  output logic [13:0]          humidity_centi,
  output logic [1:0]           status
);

  // stage 1: products
  logic        v1;
  logic [30:0] t_prod;
  logic [29:0] h_prod;
  logic [1:0]  st1;
  // stage 2: divide by 65535 as add of the high half plus one
  logic        v2;
  logic [30:0] t_sum;
  logic [29:0] h_sum;
  logic [1:0]  st2;

  logic out_free;
  logic s2_free;
  logic s1_free;
  logic [14:0] t_quot;

  // ready chain from the output back to the queue
  assign out_free = !out_valid || !out_stall;
  assign s2_free  = !v2 || out_free;
  assign s1_free  = !v1 || s2_free;
  assign pop      = head.valid && s1_free;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        v1 <= head.valid;
      end
      if (s2_free) begin
        v2 <= v1;
      end
      if (out_free) begin
        out_valid <= v2;
      end
    end
  end

  // constant multiplies
  always_ff @(posedge clk) begin
    if (s1_free) begin
      t_prod <= 31'(head.frame.temp_code) * 31'(htfd_pkg::TEMP_SCALE);
      h_prod <= 30'(head.frame.hum_code) * 30'(htfd_pkg::HUM_SCALE);
      st1    <= head.frame.status;
    end
  end

  // floor(x/65535) = (x + (x >> 16) + 1) >> 16 for x below 65535*65536
  always_ff @(posedge clk) begin
    if (s2_free) begin
      t_sum <= t_prod + (t_prod >> 16) + 31'd1;
      h_sum <= h_prod + (h_prod >> 16) + 30'd1;
      st2   <= st1;
    end
  end

  assign t_quot = t_sum[30:16];

  // output register
  always_ff @(posedge clk) begin
    if (out_free) begin
      temperature_centi <= signed'(t_quot - htfd_pkg::TEMP_OFFSET);
      humidity_centi    <= h_sum[29:16];
      status            <= st2;
    end
  end

endmodule

// ----- hw/rtl/htfd_checker.sv -----
// htfd_port_checks: port-level checks of the frame decoder, bound to the top level
// depends on htfd_pkg for status codes and humidity_temperature_frame_decoder_core

module htfd_port_checks (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [14:0] temperature_centi,
  input logic [13:0]        humidity_centi,
  input logic [1:0]         status
);

  // nothing is in flight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("result or stall present right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(temperature_centi)
      && $stable(humidity_centi) && $stable(status))
    else $error("stalled result changed");

  // status is one of the defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == htfd_pkg::STATUS_OK) || (status == htfd_pkg::STATUS_CRC)
      || (status == htfd_pkg::STATUS_RANGE))
    else $error("undefined status code");

  // scaled values stay in their physical range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (temperature_centi >= -15'sd4500) && (temperature_centi <= 15'sd13000)
      && (humidity_centi <= 14'd10000))
    else $error("scaled result out of range");

endmodule

bind humidity_temperature_frame_decoder_core htfd_port_checks u_htfd_checker (
  .clk               (clk),
  .rst               (rst),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .temperature_centi (temperature_centi),
  .humidity_centi    (humidity_centi),
  .status            (status)
);
